// ===== rtl/core/dbnc_pkg.sv =====
`timescale 1ns / 1ps

package dbnc_pkg;

    localparam int NUM_PINS    = 40;
    localparam int TICK_PERIOD = 1;
    localparam int FIRST_PIN   = 0;

    localparam int PIN_W    = 6;
    localparam int LEVELS_W = 40;
    localparam int RAW_W    = 16;
    localparam int COUNT_W  = 17;
    localparam int IDX_W    = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    // threshold entry: notify flag on top of the tick threshold
    localparam int THR_ENTRY_W = RAW_W + 1;

    // ceil(raw / TICK_PERIOD) as (raw + P - 1) * ceil(2^S / P) >> S, exact for the 17-bit sum
    localparam int NUM_W      = RAW_W + 1;
    localparam int TICK_SHIFT = NUM_W + 10;
    localparam int RECIP_W    = TICK_SHIFT + 1;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TICK_RECIP =
        RECIP_W'(((64'd1 << TICK_SHIFT) + 64'(TICK_PERIOD) - 64'd1) / 64'(TICK_PERIOD));

    typedef enum logic [1:0] {
        CMD_EDGE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_REG   = 2'd2,
        CMD_UNREG = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [PIN_W-1:0] pin;
        logic             level;
    } t_note;

endpackage

// ===== rtl/core/dbnc_ram.sv =====
`timescale 1ns / 1ps

module dbnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/multi_pin_gpio_debouncer_core.sv =====
`timescale 1ns / 1ps

// Per-pin debouncer for up to NUM_PINS pins, driven by edge, tick, register and unregister
// beats. Edge, register and unregister beats, and a tick that finds the timer stopped or
// nothing pending, are handled in the idle state. A tick that starts a scan walks the tick
// counts, which live in a single-port-read memory, one pin entry a cycle, the first read
// starting with the tick and a done state flushing the last notification. The walk pauses
// while a second notification waits on a stalled output register, and so does the flush.
// Notifications of one tick come out in pin order, the final one with o_last set; the next
// beat is taken while the last notification still waits at the output.
// Threshold and count stores keep a valid bit per pin, so no clearing pass follows reset.

module multi_pin_gpio_debouncer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_command,
    input  logic [dbnc_pkg::PIN_W-1:0]     i_pin,
    input  logic [dbnc_pkg::LEVELS_W-1:0]  i_pin_levels,
    input  logic [dbnc_pkg::RAW_W-1:0]     i_threshold_raw,
    input  logic                           i_initial_level,
    input  logic                           i_notify_enable,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dbnc_pkg::PIN_W-1:0]     o_settled_pin,
    output logic                           o_settled_level,
    output logic                           o_last
);

    localparam int NP = dbnc_pkg::NUM_PINS;
    localparam int IW = dbnc_pkg::IDX_W;
    localparam int CW = dbnc_pkg::COUNT_W;
    localparam int RW = dbnc_pkg::RAW_W;
    localparam logic [IW-1:0] IDX_FIRST = IW'(dbnc_pkg::FIRST_PIN);
    localparam logic [IW-1:0] IDX_LAST  = IW'(NP - 1);

    dbnc_pkg::t_state r_state, n_state;
    logic [NP-1:0]    r_pending, n_pending;
    logic [NP-1:0]    r_latched, n_latched;
    logic [NP-1:0]    r_cnt_vld, n_cnt_vld;
    logic [NP-1:0]    r_thr_vld, n_thr_vld;
    logic [NP-1:0]    r_sample, n_sample;
    logic             r_timer, n_timer;
    logic [IW-1:0]    r_idx, n_idx;
    dbnc_pkg::t_note  r_hold, n_hold;
    dbnc_pkg::t_note  r_out, n_out;
    logic             r_out_last, n_out_last;

    logic                               w_accept;
    logic                               w_pin_ok;
    logic [IW-1:0]                      w_pin_idx;
    logic [63:0]                        w_levels_ext;
    logic [dbnc_pkg::NUM_W-1:0]         w_num;
    logic [dbnc_pkg::PROD_W-1:0]        w_prod;
    logic [RW-1:0]                      w_ticks;

    logic                               w_rd_en;
    logic [IW-1:0]                      w_rd_addr;
    logic                               w_cnt_wr_en;
    logic [CW-1:0]                      w_cnt_wr_data;
    logic                               w_thr_wr_en;
    logic [dbnc_pkg::THR_ENTRY_W-1:0]   w_thr_wr_data;
    logic [CW-1:0]                      w_cnt_rdata;
    logic [dbnc_pkg::THR_ENTRY_W-1:0]   w_thr_rdata;

    logic [CW-1:0]                      w_cnt;
    logic [RW-1:0]                      w_thr;
    logic                               w_ntf;
    logic                               w_act;
    logic                               w_settle;
    logic                               w_emit;
    logic                               w_out_free;

    assign o_in_stall = (r_state != dbnc_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out.valid || !i_out_stall;

    assign w_pin_ok  = ({1'b0, i_pin} >= 7'(dbnc_pkg::FIRST_PIN)) && ({1'b0, i_pin} < 7'(NP));
    assign w_pin_idx = i_pin[IW-1:0];
    assign w_levels_ext = 64'(i_pin_levels);

    // rounding up to whole ticks
    assign w_num   = {1'b0, i_threshold_raw} + dbnc_pkg::NUM_W'(dbnc_pkg::TICK_PERIOD - 1);
    assign w_prod  = dbnc_pkg::PROD_W'(w_num) * dbnc_pkg::PROD_W'(dbnc_pkg::TICK_RECIP);
    assign w_ticks = w_prod[dbnc_pkg::TICK_SHIFT +: RW];

    assign w_thr_wr_en   = w_accept && (dbnc_pkg::t_cmd'(i_command) == dbnc_pkg::CMD_REG)
                           && w_pin_ok;
    assign w_thr_wr_data = {i_notify_enable, w_ticks};

    // entries with a clear valid bit read as zero
    assign w_cnt = r_cnt_vld[r_idx] ? w_cnt_rdata : '0;
    assign w_thr = r_thr_vld[r_idx] ? w_thr_rdata[RW-1:0] : '0;
    assign w_ntf = r_thr_vld[r_idx] && w_thr_rdata[RW];

    assign w_act    = r_pending[r_idx] && (r_latched[r_idx] != r_sample[r_idx]);
    assign w_settle = w_act && (w_cnt > {1'b0, w_thr});
    assign w_emit   = w_settle && w_ntf;

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_latched  = r_latched;
        n_cnt_vld  = r_cnt_vld;
        n_thr_vld  = r_thr_vld;
        n_sample   = r_sample;
        n_timer    = r_timer;
        n_idx      = r_idx;
        n_hold     = r_hold;
        n_out      = r_out;
        n_out_last = r_out_last;

        w_rd_en       = 1'b0;
        w_rd_addr     = IDX_FIRST;
        w_cnt_wr_en   = 1'b0;
        w_cnt_wr_data = '0;

        if (r_out.valid && !i_out_stall) begin
            n_out.valid = 1'b0;
        end

        case (r_state)
            dbnc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (dbnc_pkg::t_cmd'(i_command))
                        dbnc_pkg::CMD_EDGE: begin
                            if (w_pin_ok) begin
                                n_pending[w_pin_idx] = 1'b1;
                                n_timer              = 1'b1;
                            end
                        end
                        dbnc_pkg::CMD_TICK: begin
                            if (r_timer) begin
                                if (r_pending == '0) begin
                                    n_timer = 1'b0;
                                end else begin
                                    n_sample = w_levels_ext[NP-1:0];
                                    n_idx    = IDX_FIRST;
                                    w_rd_en  = 1'b1;
                                    n_state  = dbnc_pkg::ST_SCAN;
                                end
                            end
                        end
                        dbnc_pkg::CMD_REG: begin
                            if (w_pin_ok) begin
                                n_thr_vld[w_pin_idx] = 1'b1;
                                n_latched[w_pin_idx] = i_initial_level;
                            end
                        end
                        dbnc_pkg::CMD_UNREG: begin
                            if (w_pin_ok) begin
                                n_thr_vld[w_pin_idx] = 1'b0;
                                n_cnt_vld[w_pin_idx] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dbnc_pkg::ST_SCAN: begin
                // a second notification needs the held one pushed out first
                if (!(w_emit && r_hold.valid && !w_out_free)) begin
                    if (w_act) begin
                        w_cnt_wr_en      = 1'b1;
                        w_cnt_wr_data    = w_settle ? '0 : w_cnt + CW'(1);
                        n_cnt_vld[r_idx] = 1'b1;
                    end
                    if (w_settle) begin
                        n_latched[r_idx] = r_sample[r_idx];
                        n_pending[r_idx] = 1'b0;
                    end
                    if (w_emit) begin
                        if (r_hold.valid) begin
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                        end
                        n_hold.valid = 1'b1;
                        n_hold.pin   = dbnc_pkg::PIN_W'(r_idx);
                        n_hold.level = r_sample[r_idx];
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = dbnc_pkg::ST_DONE;
                    end else begin
                        n_idx     = r_idx + IW'(1);
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + IW'(1);
                    end
                end
            end
            dbnc_pkg::ST_DONE: begin
                if (!r_hold.valid) begin
                    n_state = dbnc_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    n_out        = r_hold;
                    n_out_last   = 1'b1;
                    n_hold.valid = 1'b0;
                    n_state      = dbnc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dbnc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dbnc_pkg::ST_IDLE;
            r_pending   <= '0;
            r_latched   <= '0;
            r_cnt_vld   <= '0;
            r_thr_vld   <= '0;
            r_timer     <= 1'b0;
            r_hold.valid <= 1'b0;
            r_out.valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_latched   <= n_latched;
            r_cnt_vld   <= n_cnt_vld;
            r_thr_vld   <= n_thr_vld;
            r_timer     <= n_timer;
            r_hold.valid <= n_hold.valid;
            r_out.valid  <= n_out.valid;
        end
        r_sample     <= n_sample;
        r_idx        <= n_idx;
        r_hold.pin   <= n_hold.pin;
        r_hold.level <= n_hold.level;
        r_out.pin    <= n_out.pin;
        r_out.level  <= n_out.level;
        r_out_last   <= n_out_last;
    end

    dbnc_ram #(
        .WIDTH (CW),
        .DEPTH (NP)
    ) u_cnt_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_cnt_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_cnt_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_cnt_rdata)
    );

    dbnc_ram #(
        .WIDTH (dbnc_pkg::THR_ENTRY_W),
        .DEPTH (NP)
    ) u_thr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_thr_wr_en),
        .i_wr_addr (w_pin_idx),
        .i_wr_data (w_thr_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_thr_rdata)
    );

    assign o_out_valid     = r_out.valid;
    assign o_settled_pin   = r_out.pin;
    assign o_settled_level = r_out.level;
    assign o_last          = r_out_last;

    a_hold_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbnc_pkg::ST_IDLE) |-> !r_hold.valid)
        else $error("held notification left behind at end of scan");

    a_timer_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer |-> (r_pending == '0))
        else $error("pin pending while tick timer stopped");

    a_out_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out.valid) |-> ($past(r_state) != dbnc_pkg::ST_IDLE))
        else $error("notification loaded outside a scan");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dbnc_pkg::ST_SCAN) |-> ((r_idx >= IDX_FIRST) && (r_idx <= IDX_LAST)))
        else $error("scan index out of pin range");

endmodule

// ===== sim/debounce_settle_checker.sv =====
`timescale 1ns / 1ps

module debounce_settle_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [dbnc_pkg::PIN_W-1:0]    i_pin,
    input  logic [dbnc_pkg::LEVELS_W-1:0] i_pin_levels,
    input  logic [dbnc_pkg::RAW_W-1:0]    i_threshold_raw,
    input  logic                          i_initial_level,
    input  logic                          i_notify_enable,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [dbnc_pkg::PIN_W-1:0]    i_settled_pin,
    input  logic                          i_settled_level,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_waiting
);

    typedef struct packed {
        logic [dbnc_pkg::PIN_W-1:0] pin;
        logic                       level;
        logic                       last;
    } t_settle_note;

    t_settle_note                  settle_q[$];
    logic [dbnc_pkg::LEVELS_W-1:0] pend_mask;
    logic [dbnc_pkg::LEVELS_W-1:0] latch_lvl;
    logic [dbnc_pkg::COUNT_W-1:0]  pin_count  [dbnc_pkg::NUM_PINS];
    logic [dbnc_pkg::RAW_W-1:0]    pin_thr    [dbnc_pkg::NUM_PINS];
    logic                          pin_notify [dbnc_pkg::NUM_PINS];
    logic                          timer_on;
    int                            mismatches;

    always @(posedge i_clk) begin
        t_settle_note want;
        t_settle_note note;
        t_settle_note found[$];
        int           i;
        logic         pin_in_range;

        pin_in_range = int'(i_pin) >= dbnc_pkg::FIRST_PIN && int'(i_pin) < dbnc_pkg::NUM_PINS;
        if (!i_rst_n) begin
            pend_mask = '0;
            latch_lvl = '0;
            timer_on  = 1'b0;
            for (i = 0; i < dbnc_pkg::NUM_PINS; i++) begin
                pin_count[i]  = '0;
                pin_thr[i]    = '0;
                pin_notify[i] = 1'b0;
            end
            settle_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    dbnc_pkg::CMD_EDGE: begin
                        if (pin_in_range) begin
                            pend_mask[i_pin] = 1'b1;
                            timer_on = 1'b1;
                        end
                    end
                    dbnc_pkg::CMD_REG: begin
                        if (pin_in_range) begin
                            // round up to whole ticks
                            pin_thr[i_pin] = dbnc_pkg::RAW_W'(
                                (int'(i_threshold_raw) + dbnc_pkg::TICK_PERIOD - 1)
                                / dbnc_pkg::TICK_PERIOD);
                            pin_notify[i_pin] = i_notify_enable;
                            latch_lvl[i_pin] = i_initial_level;
                        end
                    end
                    dbnc_pkg::CMD_UNREG: begin
                        if (pin_in_range) begin
                            pin_thr[i_pin]    = '0;
                            pin_count[i_pin]  = '0;
                            pin_notify[i_pin] = 1'b0;
                        end
                    end
                    default: begin
                        // tick: ignored while stopped, stops the timer when nothing is pending
                        if (timer_on && pend_mask == '0) begin
                            timer_on = 1'b0;
                        end else if (timer_on) begin
                            found.delete();
                            for (i = dbnc_pkg::FIRST_PIN; i < dbnc_pkg::NUM_PINS; i++) begin
                                if (pend_mask[i] && latch_lvl[i] != i_pin_levels[i]) begin
                                    if (pin_count[i] > dbnc_pkg::COUNT_W'(pin_thr[i])) begin
                                        if (pin_notify[i]) begin
                                            note.pin   = dbnc_pkg::PIN_W'(i);
                                            note.level = i_pin_levels[i];
                                            note.last  = 1'b0;
                                            found.push_back(note);
                                        end
                                        latch_lvl[i] = i_pin_levels[i];
                                        pin_count[i] = '0;
                                        pend_mask[i] = 1'b0;
                                    end else begin
                                        pin_count[i] = pin_count[i] + 1'b1;
                                    end
                                end
                            end
                            for (i = 0; i < found.size(); i++) begin
                                note = found[i];
                                note.last = (i == found.size() - 1);
                                settle_q.push_back(note);
                            end
                        end
                    end
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (settle_q.size() == 0) begin
                    mismatches++;
                    $error("settled beat with nothing expected: pin %0d level %0d",
                           i_settled_pin, i_settled_level);
                end else begin
                    want = settle_q.pop_front();
                    if (want.pin != i_settled_pin) begin
                        mismatches++;
                        $error("settled_pin: expected %0d, got %0d", want.pin, i_settled_pin);
                    end
                    if (want.level != i_settled_level) begin
                        mismatches++;
                        $error("settled_level: expected %0d, got %0d",
                               want.level, i_settled_level);
                    end
                    if (want.last != i_last) begin
                        mismatches++;
                        $error("last: expected %0d, got %0d", want.last, i_last);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_waiting    <= settle_q.size();
    end

endmodule

// ===== sim/multi_pin_gpio_debouncer_core_tb.sv =====
`timescale 1ns / 1ps

module multi_pin_gpio_debouncer_core_tb;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 100;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_stall;
    logic [1:0]                    command       = '0;
    logic [dbnc_pkg::PIN_W-1:0]    pin           = '0;
    logic [dbnc_pkg::LEVELS_W-1:0] pin_levels    = '0;
    logic [dbnc_pkg::RAW_W-1:0]    threshold_raw = '0;
    logic                          initial_level = 1'b0;
    logic                          notify_enable = 1'b0;
    logic                          out_valid;
    logic                          out_stall     = 1'b0;
    logic [dbnc_pkg::PIN_W-1:0]    settled_pin;
    logic                          settled_level;
    logic                          last;

    // physical line levels that the bursts toggle
    logic [dbnc_pkg::LEVELS_W-1:0] line_levels   = '0;
    int                            hold_requests = 0;
    int                            hold_served   = 0;
    logic                          tx_idle_on    = 1'b1;
    logic                          rx_idle_on    = 1'b1;
    int                            live_beats    = 0;
    int                            fail_count;
    int                            waiting;

    always #5 clk = ~clk;

    multi_pin_gpio_debouncer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (command),
        .i_pin           (pin),
        .i_pin_levels    (pin_levels),
        .i_threshold_raw (threshold_raw),
        .i_initial_level (initial_level),
        .i_notify_enable (notify_enable),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_settled_pin   (settled_pin),
        .o_settled_level (settled_level),
        .o_last          (last)
    );

    debounce_settle_checker u_settle_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (command),
        .i_pin           (pin),
        .i_pin_levels    (pin_levels),
        .i_threshold_raw (threshold_raw),
        .i_initial_level (initial_level),
        .i_notify_enable (notify_enable),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_settled_pin   (settled_pin),
        .i_settled_level (settled_level),
        .i_last          (last),
        .o_fail_count    (fail_count),
        .o_waiting       (waiting)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic [dbnc_pkg::LEVELS_W-1:0] rand_levels();
        return dbnc_pkg::LEVELS_W'({$urandom(), $urandom()});
    endfunction

    task automatic send_beat(input dbnc_pkg::t_cmd cmd, input logic [dbnc_pkg::PIN_W-1:0] p,
                             input logic [dbnc_pkg::LEVELS_W-1:0] levels,
                             input logic [dbnc_pkg::RAW_W-1:0] raw,
                             input logic init, input logic ntf);
        int gap;
        gap = tx_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        pin           <= p;
        pin_levels    <= levels;
        threshold_raw <= raw;
        initial_level <= init;
        notify_enable <= ntf;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (cmd == dbnc_pkg::CMD_TICK || p < dbnc_pkg::NUM_PINS)
            live_beats++;
    endtask

    task automatic send_edge(input int p);
        send_beat(dbnc_pkg::CMD_EDGE, dbnc_pkg::PIN_W'(p), rand_levels(),
                  dbnc_pkg::RAW_W'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    task automatic send_tick(input logic [dbnc_pkg::LEVELS_W-1:0] levels);
        send_beat(dbnc_pkg::CMD_TICK, dbnc_pkg::PIN_W'($urandom_range(0, 63)), levels,
                  dbnc_pkg::RAW_W'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    task automatic send_reg(input int p, input int raw, input logic init, input logic ntf);
        send_beat(dbnc_pkg::CMD_REG, dbnc_pkg::PIN_W'(p), rand_levels(),
                  dbnc_pkg::RAW_W'(raw), init, ntf);
    endtask

    task automatic send_unreg(input int p);
        send_beat(dbnc_pkg::CMD_UNREG, dbnc_pkg::PIN_W'(p), rand_levels(),
                  dbnc_pkg::RAW_W'($urandom()), 1'($urandom()), 1'($urandom()));
    endtask

    // output side: random stalls, plus the long hold-off when asked for
    initial begin : receiver
        int n;
        forever begin
            @(posedge clk);
            if (hold_served < hold_requests) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served++;
            end else begin
                n = rx_idle_on ? idle_len() : 0;
                out_stall <= (n > 0);
                if (n > 1)
                    repeat (n - 1) @(posedge clk);
            end
        end
    end

    // stretches with and without output stalls
    initial begin : rx_mode
        forever begin
            @(negedge clk);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            repeat ($urandom_range(50, 300)) @(negedge clk);
        end
    end

    initial begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("** multi_pin_gpio_debouncer_core: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int                            p;
        int                            k;
        int                            n;
        int                            start;
        logic [dbnc_pkg::LEVELS_W-1:0] bounce;
        logic [dbnc_pkg::LEVELS_W-1:0] lv;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks with the timer stopped, edge on a pin beyond the range
        send_tick('1);
        send_edge(63);
        send_tick('1);
        send_reg(0, 0, 1'b0, 1'b1);
        send_reg(39, 0, 1'b1, 1'b1);
        send_reg(5, 16'hFFFF, 1'b0, 1'b1);
        send_reg(12, 2, 1'b0, 1'b1);
        send_reg(40, 3, 1'b1, 1'b1);
        send_edge(0);
        send_edge(39);
        send_edge(5);
        send_edge(7);
        send_edge(12);
        lv = '0;
        lv[0]  = 1'b1;
        lv[5]  = 1'b1;
        lv[7]  = 1'b1;
        lv[12] = 1'b1;
        send_tick(lv);
        send_tick(lv);
        // pins 5 and 12 bounce back: count held, pin stays pending
        bounce = lv;
        bounce[5]  = 1'b0;
        bounce[12] = 1'b0;
        send_tick(bounce);
        send_tick(lv);
        send_tick(lv);
        send_unreg(5);
        send_tick(lv);
        send_tick(lv);
        send_tick('0);
        send_tick('0);
        send_unreg(63);

        // fill the block: all pins settle in one tick while the output is held off
        tx_idle_on = 1'b0;
        for (p = dbnc_pkg::FIRST_PIN; p < dbnc_pkg::NUM_PINS; p++) begin
            send_unreg(p);
            send_reg(p, 0, line_levels[p], 1'b1);
        end
        line_levels = ~line_levels;
        for (p = dbnc_pkg::FIRST_PIN; p < dbnc_pkg::NUM_PINS; p++)
            send_edge(p);
        send_tick(line_levels);
        hold_requests <= hold_requests + 1;
        repeat (3) send_tick(line_levels);

        // bursts of toggling pins followed by noisy ticks
        start = live_beats;
        while (live_beats - start < RANDOM_BEATS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            k = $urandom_range(1, 6);
            repeat (k) begin
                p = $urandom_range(dbnc_pkg::FIRST_PIN, dbnc_pkg::NUM_PINS - 1);
                case ($urandom_range(0, 7))
                    0, 1: send_reg(p, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 3),
                                   1'($urandom()), $urandom_range(0, 3) != 0);
                    2: send_unreg(p);
                    default: ;
                endcase
                line_levels[p] = ~line_levels[p];
                send_edge(p);
            end
            n = $urandom_range(1, 7);
            repeat (n) begin
                bounce = '0;
                if ($urandom_range(0, 2) == 0)
                    bounce[$urandom_range(0, dbnc_pkg::LEVELS_W - 1)] = 1'b1;
                send_tick(line_levels ^ bounce);
            end
            case ($urandom_range(0, 5))
                0: send_beat(dbnc_pkg::t_cmd'($urandom_range(0, 3)),
                             dbnc_pkg::PIN_W'($urandom_range(dbnc_pkg::NUM_PINS, 63)),
                             rand_levels(), dbnc_pkg::RAW_W'($urandom()), 1'($urandom()),
                             1'($urandom()));
                1: send_tick(rand_levels());
                2: send_unreg($urandom_range(dbnc_pkg::FIRST_PIN, dbnc_pkg::NUM_PINS - 1));
                default: ;
            endcase
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (3 * dbnc_pkg::NUM_PINS) @(posedge clk);
        if (fail_count == 0 && waiting == 0)
            $display("** multi_pin_gpio_debouncer_core: PASSED **");
        else
            $display("** multi_pin_gpio_debouncer_core: FAILED **");
        $finish;
    end

endmodule

// ===== multi_pin_gpio_debouncer_core.f =====
rtl/core/dbnc_pkg.sv
rtl/core/dbnc_ram.sv
rtl/core/multi_pin_gpio_debouncer_core.sv
sim/debounce_settle_checker.sv
sim/multi_pin_gpio_debouncer_core_tb.sv
